// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock with an active-low reset.
`define ASSERT_AT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error(msg);

// Assert a property on the default clk / rst_n pair.
`define ASSERT_CLKD(lbl, prop, msg) `ASSERT_AT(lbl, clk, rst_n, prop, msg)

`endif

// ----- rtl/dsf_pkg.sv -----
// ----------------------------------------------------------------------------
// dsf_pkg
// Beat types, character codes and weight table helper for the decimal
// string to fixed point converter.
// ----------------------------------------------------------------------------
package dsf_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } dsf_in_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               overflow;
    } dsf_out_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int          INT_W   = 31;
    localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

    // Weight index saturates at the last entry, which is zero for any
    // supported weight width.
    localparam int WT_DEPTH = 16;
    localparam int WT_IDX_W = 4;

    // Weight after k fraction digits: 0.1 rounded, then truncated by ten k times.
    function automatic logic [63:0] weight_at(input int w, input int k);
        logic [63:0] x;
        x = ((64'd1 << w) + 64'd5) / 64'd10;
        for (int i = 0; i < k; i++)
        begin
            x = x / 64'd10;
        end
        return x;
    endfunction

endpackage

// ----- rtl/decimal_string_to_fixed.sv -----
// The result beat is registered and appears the cycle after last_char is taken.
// One character per unstalled cycle; the parse state updates in a single pass.
// The char channel stalls only while a finished result waits in the output
// register and the downstream side stalls it.
// Reset clears the parse state to the start of a string and empties the output.
// ----------------------------------------------------------------------------
// decimal_string_to_fixed
// Streams ASCII characters and returns the parsed number as signed fixed point.
// ----------------------------------------------------------------------------
module decimal_string_to_fixed #(
    parameter int FRAC_BITS   = 32,
    parameter int WEIGHT_BITS = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  dsf_pkg::dsf_in_t  char_data,
    output logic              num_valid,
    input  logic              num_stall,
    output dsf_pkg::dsf_out_t num_data
);
    import dsf_pkg::*;

    logic     take;
    logic     load;
    dsf_out_t result;
    logic     num_valid_reg;
    dsf_out_t num_data_reg;

    assign char_stall = num_valid_reg && num_stall;
    assign take       = char_valid && !char_stall;
    assign load       = take && char_data.last_char;

    dsf_parser #(
        .FRAC_BITS   (FRAC_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .beat   (char_data),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_valid_reg <= 1'b0;
        else if (load)
            num_valid_reg <= 1'b1;
        else if (!num_stall)
            num_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            num_data_reg <= result;
    end

    assign num_valid = num_valid_reg;
    assign num_data  = num_data_reg;

endmodule

// ----- rtl/dsf_parser.sv -----
// ----------------------------------------------------------------------------
// dsf_parser
// Per-character parse state: sign, saturating integer part, weighted
// fraction sum. Produces the result of the current beat combinationally.
// ----------------------------------------------------------------------------
module dsf_parser #(
    parameter int FRAC_BITS   = 32,
    parameter int WEIGHT_BITS = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  dsf_pkg::dsf_in_t  beat,
    output dsf_pkg::dsf_out_t result
);
    import dsf_pkg::*;

    localparam logic [1:0] PH_SIGN = 2'd0;
    localparam logic [1:0] PH_INT  = 2'd1;
    localparam logic [1:0] PH_FRAC = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam int WP = WEIGHT_BITS + 4;
    localparam int IP = INT_W + 4;
    localparam logic [WEIGHT_BITS-1:0] FRAC_MAX = {WEIGHT_BITS{1'b1}};
    localparam logic [WT_IDX_W-1:0]    IDX_LAST = WT_IDX_W'(WT_DEPTH - 1);

    logic [1:0]             phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [INT_W-1:0]       int_reg, int_next;
    logic [WEIGHT_BITS-1:0] frac_reg, frac_next;
    logic [WT_IDX_W-1:0]    idx_reg, idx_next;
    logic                   sat_reg, sat_next;

    logic [WEIGHT_BITS-1:0] weight_tab [WT_DEPTH];
    logic [WEIGHT_BITS-1:0] weight;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [IP-1:0]          int_sum;
    logic [WP-1:0]          frac_sum;
    logic                   int_add;
    logic                   frac_add;
    logic [FRAC_BITS-1:0]   frac_q;
    logic [63:0]            mag;

    genvar k;
    generate
        for (k = 0; k < WT_DEPTH; k++)
        begin : gen_weight
            assign weight_tab[k] = WEIGHT_BITS'(weight_at(WEIGHT_BITS, k));
        end
    endgenerate

    assign weight   = weight_tab[idx_reg];
    assign is_digit = (beat.char_code >= CH_ZERO) && (beat.char_code <= CH_NINE);
    assign digit    = is_digit ? beat.char_code[3:0] : 4'd0;

    // value * 10 + digit as two shifted copies
    assign int_sum  = (IP'(int_reg) << 3) + (IP'(int_reg) << 1) + IP'(digit);
    assign frac_sum = WP'(frac_reg) + WP'(weight) * WP'(digit);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        int_add    = 1'b0;
        frac_add   = 1'b0;
        unique case (phase_reg)
            PH_SIGN:
            begin
                priority if (beat.char_code == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_INT;
                end
                else if (beat.char_code == CH_PLUS)
                    phase_next = PH_INT;
                else if (is_digit)
                begin
                    int_add    = 1'b1;
                    phase_next = PH_INT;
                end
                else if (beat.char_code == CH_DOT)
                    phase_next = PH_FRAC;
                else
                    phase_next = PH_DONE;
            end
            PH_INT:
            begin
                priority if (is_digit)
                    int_add = 1'b1;
                else if (beat.char_code == CH_DOT)
                    phase_next = PH_FRAC;
                else
                    phase_next = PH_DONE;
            end
            PH_FRAC:
            begin
                if (is_digit)
                    frac_add = 1'b1;
                else
                    phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_comb
    begin
        int_next = int_reg;
        sat_next = sat_reg;
        if (int_add)
        begin
            if (int_sum > IP'(INT_MAX))
            begin
                int_next = INT_MAX;
                sat_next = 1'b1;
            end
            else
                int_next = int_sum[INT_W-1:0];
        end
    end

    always_comb
    begin
        frac_next = frac_reg;
        idx_next  = idx_reg;
        if (frac_add)
        begin
            frac_next = (frac_sum > WP'(FRAC_MAX)) ? FRAC_MAX : frac_sum[WEIGHT_BITS-1:0];
            idx_next  = (idx_reg == IDX_LAST) ? idx_reg : idx_reg + 1'b1;
        end
    end

    generate
        if (WEIGHT_BITS >= FRAC_BITS)
        begin : gen_frac_trunc
            assign frac_q = FRAC_BITS'(frac_next >> (WEIGHT_BITS - FRAC_BITS));
        end
        else
        begin : gen_frac_pad
            assign frac_q = {frac_next, {(FRAC_BITS - WEIGHT_BITS){1'b0}}};
        end
    endgenerate

    // Integer and fraction bits do not overlap: concatenate, then apply sign.
    assign mag             = (64'(int_next) << FRAC_BITS) | 64'(frac_q);
    assign result.value    = $signed(neg_next ? (64'd0 - mag) : mag);
    assign result.overflow = sat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIGN;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            idx_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (beat.last_char)
            begin
                // drop back to the start state for the next string
                phase_reg <= PH_SIGN;
                neg_reg   <= 1'b0;
                int_reg   <= '0;
                frac_reg  <= '0;
                idx_reg   <= '0;
                sat_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                int_reg   <= int_next;
                frac_reg  <= frac_next;
                idx_reg   <= idx_next;
                sat_reg   <= sat_next;
            end
        end
    end

endmodule

// ----- rtl/dsf_checker.sv -----
// ----------------------------------------------------------------------------
// dsf_port_checks
// Port-level checks on the converter's result channel and back-pressure.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsf_port_checks (
    input logic              clk,
    input logic              rst_n,
    input logic              char_valid,
    input logic              char_stall,
    input dsf_pkg::dsf_in_t  char_data,
    input logic              num_valid,
    input logic              num_stall,
    input dsf_pkg::dsf_out_t num_data
);
    import dsf_pkg::*;

    `ASSERT_CLKD(a_num_hold, (num_valid && num_stall) |=> num_valid,
                 "result beat dropped")
    `ASSERT_CLKD(a_num_stable, (num_valid && num_stall) |=> $stable(num_data),
                 "stalled result changed")
    `ASSERT_CLKD(a_backpressure, (num_valid && num_stall) |-> char_stall,
                 "char taken while result blocked")
    `ASSERT_CLKD(a_rise_after_last,
                 $rose(num_valid) |-> $past(char_valid && !char_stall && char_data.last_char),
                 "result without last char")
    `ASSERT_CLKD(a_ovf_nonzero,
                 (num_valid && num_data.overflow) |-> (num_data.value != 64'sd0),
                 "overflow with zero value")

endmodule

bind decimal_string_to_fixed dsf_port_checks u_dsf_checker (.*);
